/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the checker files.
// Each macro takes a label, the clock, a disable condition, and the two sides
// of the implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/hud_pkg.sv */
// ----------------------------------------------------------------------------
// hud_pkg
// Shared types and constants for the HCI UART packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hud_pkg;

  localparam int ByteW   = 8;
  localparam int LenW    = 16;
  localparam int CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_EVENT_CODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACL_CODE   = 2'd1;

  // reset values of the type codes
  localparam logic [ByteW-1:0] EVENT_CODE_RST = 8'h04;
  localparam logic [ByteW-1:0] ACL_CODE_RST   = 8'h02;

  // packet kinds
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ACL   = 1'b1;

  // one result beat from the parser
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] data_byte;
    logic             packet_kind;
    logic             first_byte;
    logic             is_header;
    logic             last_byte;
  } hud_result_t;

endpackage

`default_nettype wire

/* rtl/core/hci_uart_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer_top
// Splits a received UART byte stream into HCI transport packet beats.
// ----------------------------------------------------------------------------
// Usage:
//   rx_byte enters on the in_valid/in_ready channel, one byte per beat.
//   Every byte of a recognised event or ACL packet leaves on the
//   out_valid/out_ready channel with packet_kind, first_byte, is_header and
//   last_byte. A type byte matching neither code gives no output beat.
//   The type codes are written on the cfg_valid/cfg_ready channel
//   (cfg_index 0 event code, 1 ACL code); cfg_ready is always high.
//   Path: an accepted byte is registered in the input register, parsed by
//   hud_fsm from there and registered in the result register for out_valid.
//   Throughput: one byte per cycle while out_ready is high; the next parser
//   state is combinational, so the loop through the packet state sets the rate.
//   Stall: when out_ready is low with a beat held, the parser stage holds;
//   if the input register is empty, one further byte is taken into it before
//   in_ready drops.
//   Reset: both stages empty, parser waits for a type byte, codes return to
//   4 (event) and 2 (ACL).
// ----------------------------------------------------------------------------
`default_nettype none

module hci_uart_packet_deframer_top import hud_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // byte input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [ByteW-1:0]   rx_byte,
  // packet beat output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ByteW-1:0]        data_byte,
  output logic                    packet_kind,
  output logic                    first_byte,
  output logic                    is_header,
  output logic                    last_byte,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ByteW-1:0]   cfg_data
);

  logic             stage_valid;
  logic [ByteW-1:0] stage_byte;
  logic             advance;
  logic [ByteW-1:0] event_code;
  logic [ByteW-1:0] acl_code;
  hud_result_t      result;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      event_code <= EVENT_CODE_RST;
      acl_code   <= ACL_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EVENT_CODE: event_code <= cfg_data;
        CFG_ACL_CODE:   acl_code   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // parser stage moves when the result register is free or being drained
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= rx_byte;
    end
  end

  hud_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (stage_byte),
    .event_code (event_code),
    .acl_code   (acl_code),
    .result     (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      data_byte   <= result.data_byte;
      packet_kind <= result.packet_kind;
      first_byte  <= result.first_byte;
      is_header   <= result.is_header;
      last_byte   <= result.last_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hud_fsm.sv */
// ----------------------------------------------------------------------------
// hud_fsm
// Packet parser: tracks type, header and payload phases and classifies the
// byte presented on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module hud_fsm import hud_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] rx_byte,
  input  wire logic [ByteW-1:0] event_code,
  input  wire logic [ByteW-1:0] acl_code,
  output hud_result_t           result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_EVT_HDR,
    PH_ACL_HDR,
    PH_PAYLOAD
  } phase_t;

  phase_t           phase, phase_next;
  logic [1:0]       header_count, header_count_next;
  logic [LenW-1:0]  remaining, remaining_next;
  logic [ByteW-1:0] length_low, length_low_next;
  logic             kind, kind_next;

  logic [LenW-1:0]  acl_len;
  logic [LenW-1:0]  rem_dec;

  assign acl_len = {rx_byte, length_low};
  assign rem_dec = remaining - LenW'(1);

  // next state and result for the byte on rx_byte
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    remaining_next    = remaining;
    length_low_next   = length_low;
    kind_next         = kind;
    result.emit       = 1'b1;
    result.first_byte = 1'b0;
    result.is_header  = 1'b1;
    result.last_byte  = 1'b0;

    case (phase)
      PH_EVT_HDR: begin
        if (header_count == 2'd0) begin
          header_count_next = 2'd1;
        end else begin
          remaining_next    = {{(LenW-ByteW){1'b0}}, rx_byte};
          header_count_next = 2'd0;
          if (rx_byte == '0) begin
            result.last_byte = 1'b1;
            phase_next       = PH_IDLE;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end

      PH_ACL_HDR: begin
        if (header_count < 2'd2) begin
          header_count_next = header_count + 2'd1;
        end else if (header_count == 2'd2) begin
          length_low_next   = rx_byte;
          header_count_next = 2'd3;
        end else begin
          remaining_next    = acl_len;
          header_count_next = 2'd0;
          if (acl_len == '0) begin
            result.last_byte = 1'b1;
            phase_next       = PH_IDLE;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end

      PH_PAYLOAD: begin
        result.is_header = 1'b0;
        remaining_next   = rem_dec;
        if (rem_dec == '0) begin
          result.last_byte = 1'b1;
          phase_next       = PH_IDLE;
        end
      end

      default: begin
        // waiting for a type byte; event code wins when both match
        header_count_next = 2'd0;
        result.first_byte = 1'b1;
        if (rx_byte == event_code) begin
          kind_next  = KIND_EVENT;
          phase_next = PH_EVT_HDR;
        end else if (rx_byte == acl_code) begin
          kind_next  = KIND_ACL;
          phase_next = PH_ACL_HDR;
        end else begin
          result.emit = 1'b0;
        end
      end
    endcase

    result.data_byte   = rx_byte;
    result.packet_kind = kind_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_count <= 2'd0;
      remaining    <= '0;
      length_low   <= '0;
      kind         <= KIND_EVENT;
    end else if (step) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      remaining    <= remaining_next;
      length_low   <= length_low_next;
      kind         <= kind_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hud_checker.sv */
// ----------------------------------------------------------------------------
// hud_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hud_checker import hud_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [ByteW-1:0]   data_byte,
  input wire logic               packet_kind,
  input wire logic               first_byte,
  input wire logic               is_header,
  input wire logic               last_byte
);

  logic held;
  assign held = out_valid && !out_ready;

  // a type byte is a header byte and never closes a packet
  `ASSERT_IMPLY(a_first_is_header, clk, rst, out_valid && first_byte, is_header && !last_byte)

  // reset empties the output
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // a stalled beat stays valid with its data, last flag and kind unchanged
  `ASSERT_NEXT(a_stall_hold, clk, rst, held,
               out_valid && $stable(data_byte) && $stable(last_byte) && $stable(packet_kind))

  // with the output stalled and the pipe full, in_ready stays low unless out_ready is high
  `ASSERT_NEXT(a_no_take_when_full, clk, rst, held && in_valid && !in_ready, !in_ready || out_ready)

endmodule

bind hci_uart_packet_deframer_top hud_checker u_hud_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .data_byte   (data_byte),
  .packet_kind (packet_kind),
  .first_byte  (first_byte),
  .is_header   (is_header),
  .last_byte   (last_byte)
);

`default_nettype wire

/* sim/hci_uart_packet_deframer_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer_top_tb
// Self-checking bench for the HCI UART packet deframer. Byte streams of event
// and ACL packets, with noise in between, are pushed in under random idling
// and backpressure. A framing predictor in the bench works out each output
// beat, and every beat that leaves the block is compared with it in order.
// ----------------------------------------------------------------------------
module hci_uart_packet_deframer_top_tb;
  import hud_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 80;
  localparam int ITEMS_PER_SET  = 25;

  // index that maps to no register; writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    WAIT_TYPE,
    EVT_HEADER,
    ACL_HEADER,
    PAYLOAD
  } frame_state_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             kind;
    logic             first;
    logic             hdr;
    logic             last;
  } beat_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [ByteW-1:0]   rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [ByteW-1:0]   data_byte;
  logic               packet_kind;
  logic               first_byte;
  logic               is_header;
  logic               last_byte;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_data;

  // framing predictor state and its copy of the type codes
  frame_state_t       fr_state;
  logic [1:0]         hdr_idx;
  logic [LenW-1:0]    bytes_left;
  logic [ByteW-1:0]   len_lo;
  logic               cur_kind;
  logic [ByteW-1:0]   evt_code;
  logic [ByteW-1:0]   acl_code;
  beat_t              pending_beats[$];

  // run control and tallies
  bit src_idling;
  bit sink_idling;
  int hold_left;
  int idle_cycles;
  int bytes_sent;
  int beats_checked;
  int mismatches;
  int input_stalls;

  hci_uart_packet_deframer_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_byte   (data_byte),
    .packet_kind (packet_kind),
    .first_byte  (first_byte),
    .is_header   (is_header),
    .last_byte   (last_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Framing predictor: one received byte in, zero or one beat queued
  function automatic void frame_byte(input logic [ByteW-1:0] b);
    logic fin;
    fin = 1'b0;
    case (fr_state)
      EVT_HEADER: begin
        if (hdr_idx == 2'd0) begin
          hdr_idx = 2'd1;
        end else begin
          bytes_left = {8'h00, b};
          hdr_idx    = 2'd0;
          fin        = (b == 8'h00);
          fr_state   = fin ? WAIT_TYPE : PAYLOAD;
        end
        pending_beats.push_back('{b, cur_kind, 1'b0, 1'b1, fin});
      end
      ACL_HEADER: begin
        if (hdr_idx < 2'd2) begin
          hdr_idx = hdr_idx + 2'd1;
        end else if (hdr_idx == 2'd2) begin
          len_lo  = b;
          hdr_idx = 2'd3;
        end else begin
          bytes_left = {b, len_lo};
          hdr_idx    = 2'd0;
          fin        = (bytes_left == '0);
          fr_state   = fin ? WAIT_TYPE : PAYLOAD;
        end
        pending_beats.push_back('{b, cur_kind, 1'b0, 1'b1, fin});
      end
      PAYLOAD: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          fin      = 1'b1;
          fr_state = WAIT_TYPE;
        end
        pending_beats.push_back('{b, cur_kind, 1'b0, 1'b0, fin});
      end
      default: begin
        // event code wins when both codes are equal; anything else is dropped
        hdr_idx = 2'd0;
        if (b == evt_code) begin
          cur_kind = KIND_EVENT;
          fr_state = EVT_HEADER;
          pending_beats.push_back('{b, cur_kind, 1'b1, 1'b1, 1'b0});
        end else if (b == acl_code) begin
          cur_kind = KIND_ACL;
          fr_state = ACL_HEADER;
          pending_beats.push_back('{b, cur_kind, 1'b1, 1'b1, 1'b0});
        end
      end
    endcase
  endfunction

  // Monitor: register writes, output check, then input prediction
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst) begin
      fr_state   = WAIT_TYPE;
      hdr_idx    = 2'd0;
      bytes_left = '0;
      len_lo     = '0;
      cur_kind   = KIND_EVENT;
      evt_code   = EVENT_CODE_RST;
      acl_code   = ACL_CODE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EVENT_CODE: evt_code = cfg_data;
          CFG_ACL_CODE:   acl_code = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{data_byte, packet_kind, first_byte, is_header, last_byte};
        if (pending_beats.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected beat data=%02h kind=%b first=%b hdr=%b last=%b",
                     $realtime, got.data, got.kind, got.first, got.hdr, got.last);
          mismatches++;
        end else begin
          want = pending_beats.pop_front();
          beats_checked++;
          if (got !== want) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: beat %0d expected %02h/%b/%b/%b/%b got %02h/%b/%b/%b/%b",
                       $realtime, beats_checked, want.data, want.kind, want.first,
                       want.hdr, want.last, got.data, got.kind, got.first, got.hdr,
                       got.last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        frame_byte(rx_byte);
      if (in_valid && !in_ready)
        input_stalls++;
    end
  end

  // Watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= !(sink_idling && ($urandom_range(99) < 7));
    end
  end

  // Offer one byte and wait for it to be taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk);
    while (src_idling && ($urandom_range(99) < 7)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_event_pkt(input logic [ByteW-1:0] type_b,
                                input logic [ByteW-1:0] code_b,
                                input logic [ByteW-1:0] len);
    send_byte(type_b);
    send_byte(code_b);
    send_byte(len);
    for (int i = 0; i < len; i++)
      send_byte(ByteW'($urandom_range(255)));
  endtask

  task automatic send_acl_pkt(input logic [ByteW-1:0] type_b,
                              input logic [15:0] handle,
                              input logic [LenW-1:0] len);
    send_byte(type_b);
    send_byte(handle[7:0]);
    send_byte(handle[15:8]);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < len; i++)
      send_byte(ByteW'($urandom_range(255)));
  endtask

  // Stop offering, wait for every predicted beat, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset codes: noise, zero-length packets, one-byte payloads
  task automatic test_default_codes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h03);
    send_event_pkt(EVENT_CODE_RST, 8'hFF, 8'd0);
    send_acl_pkt(ACL_CODE_RST, 16'h0000, 16'd0);
    send_event_pkt(EVENT_CODE_RST, 8'h0E, 8'd1);
    send_acl_pkt(ACL_CODE_RST, 16'hFFFF, 16'd1);
    settle();
  endtask

  // Extreme codes, equal codes and a write to the spare index
  task automatic test_code_registers();
    write_reg(CFG_EVENT_CODE, 8'hFF);
    write_reg(CFG_ACL_CODE, 8'h00);
    send_byte(EVENT_CODE_RST);
    send_event_pkt(8'hFF, 8'h3E, 8'd2);
    send_acl_pkt(8'h00, 16'h0A0B, 16'd2);
    settle();
    write_reg(CFG_EVENT_CODE, 8'h7E);
    write_reg(CFG_ACL_CODE, 8'h7E);
    send_event_pkt(8'h7E, 8'h05, 8'd1);
    settle();
    write_reg(CFG_SPARE, 8'h04);
    send_byte(8'h04);
    send_event_pkt(8'h7E, 8'h10, 8'd0);
    settle();
    write_reg(CFG_EVENT_CODE, EVENT_CODE_RST);
    write_reg(CFG_ACL_CODE, ACL_CODE_RST);
  endtask

  // Receiver holds off long enough for the input side to stall
  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    send_event_pkt(evt_code, 8'h10, 8'd20);
    settle();
  endtask

  // Largest event length and an ACL length that needs its high byte,
  // sent as one long stretch with no idling on either side
  task automatic test_max_length();
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    send_event_pkt(evt_code, 8'h01, 8'hFF);
    send_acl_pkt(acl_code, 16'h1234, 16'h0100);
    settle();
    src_idling  = 1'b1;
    sink_idling = 1'b1;
  endtask

  // Random packet streams with noise, over several code settings
  task automatic test_random();
    int pkt_bytes;
    int pick;
    int len;
    for (int set = 0; set < 3; set++) begin
      case (set)
        0: begin
          write_reg(CFG_EVENT_CODE, EVENT_CODE_RST);
          write_reg(CFG_ACL_CODE, ACL_CODE_RST);
        end
        1: begin
          write_reg(CFG_EVENT_CODE, ByteW'($urandom_range(255)));
          write_reg(CFG_ACL_CODE, ByteW'($urandom_range(255)));
          // no idling on either side for this whole stretch
          src_idling  = 1'b0;
          sink_idling = 1'b0;
        end
        default: begin
          write_reg(CFG_EVENT_CODE, 8'h00);
          write_reg(CFG_ACL_CODE, 8'hFF);
        end
      endcase
      pkt_bytes = 0;
      while (pkt_bytes < ITEMS_PER_SET) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          send_byte(ByteW'($urandom_range(255)));
        end else if (pick < 55) begin
          len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
          send_event_pkt(evt_code, ByteW'($urandom_range(255)), ByteW'(len));
          pkt_bytes += 3 + len;
        end else begin
          len = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
          send_acl_pkt(acl_code, 16'($urandom_range(65535)), LenW'(len));
          pkt_bytes += 5 + len;
        end
      end
      settle();
      src_idling  = 1'b1;
      sink_idling = 1'b1;
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_EVENT_CODE;
    cfg_data    = '0;
    src_idling  = 1'b1;
    sink_idling = 1'b1;
    hold_left   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_codes();
    test_code_registers();
    test_backpressure();
    test_max_length();
    test_random();

    $display("Run covered %0d bytes in, %0d beats checked, %0d input stall cycles",
             bytes_sent, beats_checked, input_stalls);
    $display("Codes tried: reset, extreme, equal, random; lengths from zero to 256 and more");
    if (mismatches == 0 && pending_beats.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* hci_uart_packet_deframer_top.f */
+incdir+rtl/core
rtl/core/hud_pkg.sv
rtl/core/hud_fsm.sv
rtl/core/hci_uart_packet_deframer_top.sv
rtl/core/hud_checker.sv
sim/hci_uart_packet_deframer_top_tb.sv
